FILE: rtl/usbcd_pkg.sv
// Shared types and codes for the USB cable detect debouncer.
package usbcd_pkg;

   typedef enum logic [1:0] {
      ST_DISCONNECTED = 2'd0,
      ST_DEBOUNCING   = 2'd1,
      ST_POLLING      = 2'd2
   } detect_state_type;

   localparam logic [1:0] CABLE_NONE    = 2'd0;
   localparam logic [1:0] CABLE_USB     = 2'd1;
   localparam logic [1:0] CABLE_FACTORY = 2'd2;

   localparam logic [1:0] NOTIFY_NONE    = 2'd0;
   localparam logic [1:0] NOTIFY_INSERT  = 2'd1;
   localparam logic [1:0] NOTIFY_REMOVE  = 2'd2;

   localparam logic [1:0] WAIT_IRQ        = 2'd0;
   localparam logic [1:0] WAIT_SHORT_POLL = 2'd1;
   localparam logic [1:0] WAIT_LONG_POLL  = 2'd2;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_IRQ  = 1'b1;

   localparam int unsigned THRESHOLD_W = 4;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 4'd3;
   localparam logic [THRESHOLD_W-1:0] COUNT_MAX = 4'd15;

   // Register word index of the debounce threshold.
   localparam logic REG_DEBOUNCE_THRESHOLD = 1'b0;

   typedef struct packed {
      logic kind;
      logic vbus_valid;
      logic id_float;
      logic id_ground;
      logic se1_level;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] notify;
      logic [1:0] notify_cable;
      logic       apply_host_setup;
      logic       restore_detect_setup;
      logic       unmask_vbus_irq;
      logic       mask_vbus_irq;
      logic [1:0] wait_mode;
   } rsp_payload_type;

endpackage

FILE: rtl/usbcd_if.sv
// Valid/ready channel interfaces for the request and response transfers.
interface usbcd_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic vbus_valid;
   logic id_float;
   logic id_ground;
   logic se1_level;

   modport source (output valid, kind, vbus_valid, id_float, id_ground, se1_level,
                   input ready);
   modport sink   (input valid, kind, vbus_valid, id_float, id_ground, se1_level,
                   output ready);
endinterface

interface usbcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] notify;
   logic [1:0] notify_cable;
   logic       apply_host_setup;
   logic       restore_detect_setup;
   logic       unmask_vbus_irq;
   logic       mask_vbus_irq;
   logic [1:0] wait_mode;

   modport source (output valid, notify, notify_cable, apply_host_setup,
                   restore_detect_setup, unmask_vbus_irq, mask_vbus_irq, wait_mode,
                   input ready);
   modport sink   (input valid, notify, notify_cable, apply_host_setup,
                   restore_detect_setup, unmask_vbus_irq, mask_vbus_irq, wait_mode,
                   output ready);
endinterface

FILE: rtl/usbcd_core.sv
// Detection state machine: debounce counter, cable classification and result fields.
module usbcd_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [usbcd_pkg::THRESHOLD_W-1:0]      threshold,
   input  usbcd_pkg::req_payload_type             req,
   output usbcd_pkg::rsp_payload_type             rsp
);

   usbcd_pkg::detect_state_type              state_ff, state_in;
   logic                                     last_vbus_ff, last_vbus_in;
   logic [usbcd_pkg::THRESHOLD_W-1:0]        count_ff, count_in;
   logic [1:0]                               cable_ff, cable_in;

   logic [usbcd_pkg::THRESHOLD_W-1:0]        count_step;
   logic                                     debounced;
   logic                                     is_factory;
   logic                                     is_usb;

   // Count of equal samples after this tick, whether it reaches the threshold, and the cable class.
   always_comb begin
      if (req.vbus_valid == last_vbus_ff) begin
         count_step = (count_ff == usbcd_pkg::COUNT_MAX) ? count_ff
                                                         : count_ff + 1'b1;
      end else begin
         count_step = '0;
      end
      debounced  = (count_step >= threshold);
      is_factory = req.id_float & req.id_ground & ~req.se1_level;
      is_usb     = req.id_float & ~req.id_ground & ~req.se1_level;
   end

   // Next state.
   always_comb begin
      state_in     = state_ff;
      last_vbus_in = last_vbus_ff;
      count_in     = count_ff;
      cable_in     = cable_ff;
      if (req.kind == usbcd_pkg::KIND_IRQ) begin
         state_in = usbcd_pkg::ST_DEBOUNCING;
      end else begin
         case (state_ff)
            usbcd_pkg::ST_DEBOUNCING: begin
               last_vbus_in = req.vbus_valid;
               count_in     = debounced ? '0 : count_step;
               if (debounced) begin
                  if (req.vbus_valid) begin
                     if (is_factory) begin
                        cable_in = usbcd_pkg::CABLE_FACTORY;
                        state_in = usbcd_pkg::ST_DISCONNECTED;
                     end else if (is_usb) begin
                        cable_in = usbcd_pkg::CABLE_USB;
                        state_in = usbcd_pkg::ST_POLLING;
                     end else begin
                        state_in = usbcd_pkg::ST_DISCONNECTED;
                     end
                  end else begin
                     cable_in = usbcd_pkg::CABLE_NONE;
                     state_in = usbcd_pkg::ST_DISCONNECTED;
                  end
               end
            end
            usbcd_pkg::ST_POLLING: begin
               if (!req.vbus_valid) begin
                  state_in = usbcd_pkg::ST_DEBOUNCING;
               end
            end
            default: begin
               state_in = usbcd_pkg::ST_DISCONNECTED;
            end
         endcase
      end
   end

   // Result fields.
   always_comb begin
      rsp = '0;
      if (req.kind == usbcd_pkg::KIND_IRQ) begin
         rsp.mask_vbus_irq = 1'b1;
      end else if (state_ff == usbcd_pkg::ST_DEBOUNCING && debounced) begin
         if (req.vbus_valid) begin
            if (is_factory) begin
               rsp.apply_host_setup = 1'b1;
               rsp.notify           = usbcd_pkg::NOTIFY_INSERT;
               rsp.notify_cable     = usbcd_pkg::CABLE_FACTORY;
            end else if (is_usb) begin
               rsp.apply_host_setup = 1'b1;
               rsp.notify           = usbcd_pkg::NOTIFY_INSERT;
               rsp.notify_cable     = usbcd_pkg::CABLE_USB;
            end else begin
               rsp.unmask_vbus_irq = 1'b1;
            end
         end else begin
            rsp.restore_detect_setup = 1'b1;
            rsp.unmask_vbus_irq      = 1'b1;
            if (cable_ff != usbcd_pkg::CABLE_NONE) begin
               rsp.notify       = usbcd_pkg::NOTIFY_REMOVE;
               rsp.notify_cable = cable_ff;
            end
         end
      end
      case (state_in)
         usbcd_pkg::ST_DEBOUNCING: rsp.wait_mode = usbcd_pkg::WAIT_SHORT_POLL;
         usbcd_pkg::ST_POLLING:    rsp.wait_mode = usbcd_pkg::WAIT_LONG_POLL;
         default:                  rsp.wait_mode = usbcd_pkg::WAIT_IRQ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= usbcd_pkg::ST_DEBOUNCING;
         last_vbus_ff <= 1'b0;
         count_ff     <= '0;
         cable_ff     <= usbcd_pkg::CABLE_NONE;
      end else if (accept) begin
         state_ff     <= state_in;
         last_vbus_ff <= last_vbus_in;
         count_ff     <= count_in;
         cable_ff     <= cable_in;
      end
   end

endmodule

FILE: rtl/usb_cable_detect_debouncer.sv
// Top level of the USB cable detector with VBUS debounce and register port.
// Each request transfer (a poll tick with sense bits, or a VBUS interrupt) yields exactly one
// response transfer in the next cycle, held in an output register. A new request is taken in
// every cycle as long as the output register is empty or being drained in the same cycle, so
// the sustained rate is one item per clock; the state machine update is a single pass of
// small logic. The debounce threshold lives at byte address 0 of the APB-style port, resets
// to 3 and should only be written while no transfer is in flight.
module usb_cable_detect_debouncer (
   input  logic        clock,
   input  logic        reset,
   usbcd_req_if.sink   req_chan,
   usbcd_rsp_if.source rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [usbcd_pkg::THRESHOLD_W-1:0] threshold_ff;
   logic                              rsp_valid_ff;
   usbcd_pkg::rsp_payload_type        rsp_data_ff;
   usbcd_pkg::rsp_payload_type        rsp_in;
   usbcd_pkg::req_payload_type        req_data;
   logic                              accept;
   logic                              reg_write;
   logic                              reg_index;

   // Only one register exists, so reads at every address return it; writes land only at address 0.
   assign reg_index = usbcd_pkg::REG_DEBOUNCE_THRESHOLD;
   assign reg_write = psel & penable & pwrite
                      & (reg_index == usbcd_pkg::REG_DEBOUNCE_THRESHOLD);
   assign pready    = 1'b1;
   assign prdata    = {{(32 - usbcd_pkg::THRESHOLD_W){1'b0}}, threshold_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= usbcd_pkg::THRESHOLD_RESET;
      end else if (reg_write && paddr[1:0] == 2'b00) begin
         threshold_ff <= pwdata[usbcd_pkg::THRESHOLD_W-1:0];
      end
   end

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   assign req_data.kind       = req_chan.kind;
   assign req_data.vbus_valid = req_chan.vbus_valid;
   assign req_data.id_float   = req_chan.id_float;
   assign req_data.id_ground  = req_chan.id_ground;
   assign req_data.se1_level  = req_chan.se1_level;

   usbcd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .threshold (threshold_ff),
      .req       (req_data),
      .rsp       (rsp_in)
   );

   // The output register is refilled on the same edge that its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.notify               = rsp_data_ff.notify;
   assign rsp_chan.notify_cable         = rsp_data_ff.notify_cable;
   assign rsp_chan.apply_host_setup     = rsp_data_ff.apply_host_setup;
   assign rsp_chan.restore_detect_setup = rsp_data_ff.restore_detect_setup;
   assign rsp_chan.unmask_vbus_irq      = rsp_data_ff.unmask_vbus_irq;
   assign rsp_chan.mask_vbus_irq        = rsp_data_ff.mask_vbus_irq;
   assign rsp_chan.wait_mode            = rsp_data_ff.wait_mode;

endmodule
